// File: rtl/uart_tty_buffer_with_echo_top_macros.svh
// Assertion helpers shared by the block's modules.
`ifndef UART_TTY_BUFFER_WITH_ECHO_TOP_MACROS_SVH
`define UART_TTY_BUFFER_WITH_ECHO_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UTBE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define UTBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/utbe_pkg.sv
package utbe_pkg;

   // default ring depth, in bytes
   localparam int RING_DEPTH_DEF = 64;

   // event kinds
   localparam logic [1:0] KIND_PUT  = 2'd0;
   localparam logic [1:0] KIND_XMIT = 2'd1;
   localparam logic [1:0] KIND_RECV = 2'd2;
   localparam logic [1:0] KIND_READ = 2'd3;

   // special characters
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_NUL = 8'h00;

   // end-of-transmission code after reset
   localparam logic [7:0] EOT_RESET = 8'h04;

   // one input word
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_word_type;

   // one result word
   typedef struct packed {
      logic       tx_load;
      logic [7:0] tx_byte;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       read_eof;
      logic       put_refused;
   } rsp_word_type;

   // controller states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EXEC  = 3'b010,
      ST_PUSH2 = 3'b100
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic push2;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic second_push;
   } dp_sts_type;

endpackage

// File: rtl/utbe_ctrl.sv
`include "uart_tty_buffer_with_echo_top_macros.svh"

module utbe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  utbe_pkg::dp_sts_type  sts,
   output utbe_pkg::dp_cmd_type  cmd
);

   utbe_pkg::ctl_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         utbe_pkg::ST_IDLE: begin
            if (req_valid) state_in = utbe_pkg::ST_EXEC;
         end
         utbe_pkg::ST_EXEC: begin
            if (sts.out_free) begin
               state_in = sts.second_push ? utbe_pkg::ST_PUSH2 : utbe_pkg::ST_IDLE;
            end
         end
         utbe_pkg::ST_PUSH2: begin
            state_in = utbe_pkg::ST_IDLE;
         end
         default: begin
            state_in = utbe_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= utbe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   assign req_stall   = (state_ff != utbe_pkg::ST_IDLE);
   assign cmd.capture = (state_ff == utbe_pkg::ST_IDLE) && req_valid;
   assign cmd.exec    = (state_ff == utbe_pkg::ST_EXEC) && sts.out_free;
   assign cmd.push2   = (state_ff == utbe_pkg::ST_PUSH2);

   // checks
   `UTBE_ASSERT_NEXT(a_exec_waits, clock, reset,
      (state_ff == utbe_pkg::ST_EXEC) && !sts.out_free,
      state_ff == utbe_pkg::ST_EXEC, "execute left while result register full")
   `UTBE_ASSERT_NEXT(a_push2_once, clock, reset,
      state_ff == utbe_pkg::ST_PUSH2,
      state_ff == utbe_pkg::ST_IDLE, "second push did not return to idle")

endmodule

// File: rtl/utbe_dpath.sv
`include "uart_tty_buffer_with_echo_top_macros.svh"

module utbe_dpath #(
   parameter int RING_DEPTH = utbe_pkg::RING_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  utbe_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output utbe_pkg::rsp_word_type rsp_word,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data,
   input  utbe_pkg::dp_cmd_type   cmd,
   output utbe_pkg::dp_sts_type   sts
);

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);
   localparam logic [CNT_W-1:0] CNT_FULL_M1 = CNT_W'(RING_DEPTH - 1);

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   // ring storage
   logic [7:0] tx_ring_mem [RING_DEPTH];
   logic [7:0] rx_ring_mem [RING_DEPTH];

   // item and ring read registers
   logic [1:0]       kind_ff;
   logic [7:0]       byte_ff;
   logic [7:0]       tx_rd_ff, rx_rd_ff;
   logic [7:0]       eot_ff, eot_in;

   // ring pointers and flags
   logic [PTR_W-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [CNT_W-1:0] tx_count_ff, tx_count_in;
   logic [PTR_W-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [CNT_W-1:0] rx_count_ff, rx_count_in;
   logic             busy_ff, busy_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   utbe_pkg::rsp_word_type rsp_ff, rsp_in;

   // decode
   logic       is_put, is_xmit, is_recv, is_read;
   logic       is_zero, is_eot, send_lf, send_en, refused;
   logic       tx_room1, tx_room2, tx_pop, rx_pop;
   logic       w1_en, rx_wr_en, tx_wr_en;
   logic [7:0] mapped, w1_byte, tx_wr_byte;

   always_comb begin
      is_put   = (kind_ff == utbe_pkg::KIND_PUT);
      is_xmit  = (kind_ff == utbe_pkg::KIND_XMIT);
      is_recv  = (kind_ff == utbe_pkg::KIND_RECV);
      is_read  = (kind_ff == utbe_pkg::KIND_READ);
      is_zero  = (byte_ff == utbe_pkg::CH_NUL);
      is_eot   = (byte_ff == eot_ff);
      // echo maps CR to LF unless CR is the EOT code
      mapped   = (is_recv && !is_eot && byte_ff == utbe_pkg::CH_CR) ? utbe_pkg::CH_LF
                                                                    : byte_ff;
      send_lf  = (mapped == utbe_pkg::CH_LF);
      tx_room1 = (tx_count_ff < CNT_FULL);
      tx_room2 = (tx_count_ff < CNT_FULL_M1);
      // host put is refused as a whole when the ring lacks room
      refused  = is_put && !is_zero &&
                 (send_lf ? (busy_ff ? !tx_room2 : !tx_room1) : (busy_ff && !tx_room1));
      send_en  = (is_put && !is_zero && !refused) || (is_recv && !is_zero && !is_eot);
      // first ring write: LF behind a direct CR, CR when busy, or the byte itself
      w1_en    = send_en && tx_room1 && (send_lf || busy_ff);
      w1_byte  = (send_lf && busy_ff) ? utbe_pkg::CH_CR : mapped;
      tx_pop   = is_xmit && (tx_count_ff != '0);
      rx_pop   = is_read && (rx_count_ff != '0);
      rx_wr_en = cmd.exec && is_recv && !is_zero && (mapped != utbe_pkg::CH_BS) &&
                 (rx_count_ff < CNT_FULL);
      tx_wr_en = (cmd.exec && w1_en) || cmd.push2;
      tx_wr_byte = cmd.push2 ? utbe_pkg::CH_LF : w1_byte;
   end

   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;
   assign sts.second_push = send_en && send_lf && busy_ff && tx_room2;

   // result word
   always_comb begin
      rsp_in = '0;
      if (send_en && !busy_ff) begin
         rsp_in.tx_load = 1'b1;
         rsp_in.tx_byte = send_lf ? utbe_pkg::CH_CR : mapped;
      end
      if (tx_pop) begin
         rsp_in.tx_load = 1'b1;
         rsp_in.tx_byte = tx_rd_ff;
      end
      if (rx_pop) begin
         rsp_in.read_valid = 1'b1;
         rsp_in.read_byte  = rx_rd_ff;
         rsp_in.read_eof   = (rx_rd_ff == eot_ff);
      end
      rsp_in.put_refused = refused;
   end

   // state update
   always_comb begin
      tx_head_in  = tx_head_ff;
      tx_tail_in  = tx_tail_ff;
      tx_count_in = tx_count_ff;
      rx_head_in  = rx_head_ff;
      rx_tail_in  = rx_tail_ff;
      rx_count_in = rx_count_ff;
      busy_in     = busy_ff;
      eot_in      = csr_wr_en ? csr_wr_data : eot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
         if (send_en) busy_in = 1'b1;
         if (is_xmit) busy_in = tx_pop;
         if (tx_pop) begin
            tx_head_in  = ptr_inc(tx_head_ff);
            tx_count_in = tx_count_ff - 1'b1;
         end
         if (rx_pop) begin
            rx_head_in  = ptr_inc(rx_head_ff);
            rx_count_in = rx_count_ff - 1'b1;
         end
      end
      if (tx_wr_en) begin
         tx_tail_in  = ptr_inc(tx_tail_ff);
         tx_count_in = tx_count_ff + 1'b1;
      end
      if (rx_wr_en) begin
         rx_tail_in  = ptr_inc(rx_tail_ff);
         rx_count_in = rx_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         tx_count_ff  <= '0;
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         rx_count_ff  <= '0;
         busy_ff      <= 1'b0;
         eot_ff       <= utbe_pkg::EOT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         tx_head_ff   <= tx_head_in;
         tx_tail_ff   <= tx_tail_in;
         tx_count_ff  <= tx_count_in;
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         rx_count_ff  <= rx_count_in;
         busy_ff      <= busy_in;
         eot_ff       <= eot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item capture, result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_word.kind;
         byte_ff <= req_word.data_byte;
      end
      if (cmd.exec) rsp_ff <= rsp_in;
   end

   // transmit ring: one write, head read on capture
   always_ff @(posedge clock) begin
      if (tx_wr_en) tx_ring_mem[tx_tail_ff] <= tx_wr_byte;
      if (cmd.capture) tx_rd_ff <= tx_ring_mem[tx_head_ff];
   end

   // receive ring: one write, head read on capture
   always_ff @(posedge clock) begin
      if (rx_wr_en) rx_ring_mem[rx_tail_ff] <= mapped;
      if (cmd.capture) rx_rd_ff <= rx_ring_mem[rx_head_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // checks
   `UTBE_ASSERT_NOW(a_tx_count_max, clock, reset, 1'b1,
      tx_count_ff <= CNT_FULL, "transmit ring count above depth")
   `UTBE_ASSERT_NOW(a_rx_count_max, clock, reset, 1'b1,
      rx_count_ff <= CNT_FULL, "receive ring count above depth")
   `UTBE_ASSERT_NEXT(a_load_sets_busy, clock, reset, cmd.exec && rsp_in.tx_load,
      busy_ff, "transmitter load left busy clear")
   `UTBE_ASSERT_NOW(a_push2_busy, clock, reset, cmd.push2,
      busy_ff, "second push while transmitter idle")

endmodule

// File: rtl/uart_tty_buffer_with_echo_top.sv
// Channel   Ports                                   Direction
// request   req_valid, req_stall, req_word          in (stall out)
// result    rsp_valid, rsp_stall, rsp_word          out (stall in)
// control   csr_wr_en, csr_wr_data (EOT code)       in
//
// Each word is captured together with the ring head read, then executed.
// A line feed that queues both CR and LF adds a second push for the LF,
// since the transmit ring has a single write port.
// Synchronous reset clears pointers, counts, busy and the result valid flag and restores the EOT code;
// ring contents are not cleared and need no sweep.
// A waiting result does not block capture; execute holds until it is taken.
module uart_tty_buffer_with_echo_top #(
   parameter int RING_DEPTH = utbe_pkg::RING_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  utbe_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output utbe_pkg::rsp_word_type rsp_word,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data
);

   utbe_pkg::dp_cmd_type cmd;
   utbe_pkg::dp_sts_type sts;

   utbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   utbe_dpath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// File: test/uart_tty_buffer_with_echo_top_tb.sv
`timescale 1ns / 100ps

module uart_tty_buffer_with_echo_top_tb;

   localparam int DEPTH       = utbe_pkg::RING_DEPTH_DEF;
   localparam int STALL_LIMIT = 4000;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   utbe_pkg::req_word_type req_word    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   utbe_pkg::rsp_word_type rsp_word;
   logic                   csr_wr_en   = 1'b0;
   logic [7:0]             csr_wr_data = 8'h00;

   // pacing, in percent of cycles
   int req_gap_pct  = 0;
   int rsp_hold_pct = 0;

   // predicted terminal state
   logic [7:0] tx_store [DEPTH];
   logic [7:0] rx_store [DEPTH];
   int         tx_first  = 0;
   int         tx_fill   = 0;
   int         rx_first  = 0;
   int         rx_fill   = 0;
   logic       tx_active = 1'b0;
   logic [7:0] eot_now   = utbe_pkg::EOT_RESET;

   // result words still owed by the block, oldest first
   utbe_pkg::rsp_word_type tty_due [$];
   utbe_pkg::rsp_word_type want_rsp;
   int                     bad_words  = 0;
   int                     quiet_cycles = 0;

   uart_tty_buffer_with_echo_top #(.RING_DEPTH(DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // hand a byte to an idle transmitter, else queue it (dropped when full)
   function automatic void tx_send(input logic [7:0] b,
                                   inout utbe_pkg::rsp_word_type r);
      if (!tx_active) begin
         r.tx_load = 1'b1;
         r.tx_byte = b;
         tx_active = 1'b1;
      end else if (tx_fill < DEPTH) begin
         tx_store[(tx_first + tx_fill) % DEPTH] = b;
         tx_fill++;
      end
   endfunction

   function automatic utbe_pkg::rsp_word_type tty_response(
      input utbe_pkg::req_word_type w);
      utbe_pkg::rsp_word_type r;
      logic [7:0]             b;
      int                     need;
      r = '0;
      b = w.data_byte;
      case (w.kind)
         utbe_pkg::KIND_PUT: begin
            if (b != utbe_pkg::CH_NUL) begin
               // LF goes out as CR LF, so it may need two slots
               if (b == utbe_pkg::CH_LF) need = tx_active ? 2 : 1;
               else need = tx_active ? 1 : 0;
               if (DEPTH - tx_fill < need) begin
                  r.put_refused = 1'b1;
               end else begin
                  if (b == utbe_pkg::CH_LF) tx_send(utbe_pkg::CH_CR, r);
                  tx_send(b, r);
               end
            end
         end
         utbe_pkg::KIND_XMIT: begin
            if (tx_fill > 0) begin
               r.tx_load = 1'b1;
               r.tx_byte = tx_store[tx_first];
               tx_first  = (tx_first + 1) % DEPTH;
               tx_fill--;
               tx_active = 1'b1;
            end else begin
               tx_active = 1'b0;
            end
         end
         utbe_pkg::KIND_RECV: begin
            if (b != utbe_pkg::CH_NUL) begin
               // echo unless end of transmission; CR echoes as CR LF
               if (b != eot_now) begin
                  if (b == utbe_pkg::CH_CR) b = utbe_pkg::CH_LF;
                  if (b == utbe_pkg::CH_LF) tx_send(utbe_pkg::CH_CR, r);
                  tx_send(b, r);
               end
               if (b != utbe_pkg::CH_BS && rx_fill < DEPTH) begin
                  rx_store[(rx_first + rx_fill) % DEPTH] = b;
                  rx_fill++;
               end
            end
         end
         default: begin
            if (rx_fill > 0) begin
               r.read_valid = 1'b1;
               r.read_byte  = rx_store[rx_first];
               r.read_eof   = (rx_store[rx_first] == eot_now);
               rx_first     = (rx_first + 1) % DEPTH;
               rx_fill--;
            end
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Result side: random stall, checking, watchdog
   // ------------------------------------------------------------------

   function automatic string rsp_text(input utbe_pkg::rsp_word_type r);
      return $sformatf("load=%0b tx=%02h rvalid=%0b rd=%02h eof=%0b refused=%0b",
                       r.tx_load, r.tx_byte, r.read_valid, r.read_byte,
                       r.read_eof, r.put_refused);
   endfunction

   task automatic note_bad(input string msg);
      bad_words++;
      if (bad_words <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tty_due.size() == 0) begin
            note_bad({"result word with none expected: ", rsp_text(rsp_word)});
         end else begin
            want_rsp = tty_due.pop_front();
            if (rsp_word !== want_rsp)
               note_bad({"result mismatch: expected ", rsp_text(want_rsp),
                         " got ", rsp_text(rsp_word)});
         end
      end
   end

   // ends the run when neither channel moves a word for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no word moved in %0d cycles", STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // offer one word, hold it until taken, then predict its result
   task automatic send_word(input logic [1:0] kind, input logic [7:0] data);
      utbe_pkg::req_word_type w;
      w.kind      = kind;
      w.data_byte = data;
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      tty_due.push_back(tty_response(w));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tty_due.size() != 0) @(posedge clock);
   endtask

   // write the EOT code only with the block idle
   task automatic set_eot(input logic [7:0] code);
      wait_drained();
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= code;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      eot_now      = code;
   endtask

   task automatic set_pacing(input int gap_pct, input int hold_pct);
      req_gap_pct  = gap_pct;
      rsp_hold_pct = hold_pct;
   endtask

   // bytes biased toward the control characters
   function automatic logic [7:0] pick_data();
      case ($urandom_range(9))
         0:       return utbe_pkg::CH_NUL;
         1:       return utbe_pkg::CH_LF;
         2:       return utbe_pkg::CH_CR;
         3:       return utbe_pkg::CH_BS;
         4:       return eot_now;
         5:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // random events; read weight is what the other three leave of 100
   task automatic run_mix(input int count, input int w_put, input int w_xmit,
                          input int w_recv);
      int          roll;
      logic [1:0]  kind;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (roll < w_put) kind = utbe_pkg::KIND_PUT;
         else if (roll < w_put + w_xmit) kind = utbe_pkg::KIND_XMIT;
         else if (roll < w_put + w_xmit + w_recv) kind = utbe_pkg::KIND_RECV;
         else kind = utbe_pkg::KIND_READ;
         send_word(kind, pick_data());
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // every event kind, zero bytes, line ending mapping, EOT and backspace
   task automatic test_basic_paths();
      send_word(utbe_pkg::KIND_READ, 8'hFF);   // empty receive ring
      send_word(utbe_pkg::KIND_XMIT, 8'h00);   // complete while idle
      send_word(utbe_pkg::KIND_PUT,  utbe_pkg::CH_NUL);
      send_word(utbe_pkg::KIND_RECV, utbe_pkg::CH_NUL);
      send_word(utbe_pkg::KIND_PUT,  8'h41);   // straight out, now busy
      send_word(utbe_pkg::KIND_PUT,  utbe_pkg::CH_LF);   // queues CR LF
      send_word(utbe_pkg::KIND_PUT,  8'hFF);
      send_word(utbe_pkg::KIND_XMIT, 8'hFF);
      send_word(utbe_pkg::KIND_RECV, utbe_pkg::CH_CR);   // echoed as CR LF, stored as LF
      send_word(utbe_pkg::KIND_RECV, utbe_pkg::EOT_RESET);
      send_word(utbe_pkg::KIND_RECV, utbe_pkg::CH_BS);   // echoed, not stored
      send_word(utbe_pkg::KIND_RECV, 8'h7F);
      repeat (7) send_word(utbe_pkg::KIND_XMIT, 8'h00);
      send_word(utbe_pkg::KIND_PUT,  utbe_pkg::CH_LF);   // idle: CR now, LF queued
      send_word(utbe_pkg::KIND_READ, 8'h00);
      send_word(utbe_pkg::KIND_READ, 8'h00);   // end of file
      send_word(utbe_pkg::KIND_READ, 8'h00);
      send_word(utbe_pkg::KIND_READ, 8'h00);   // empty again
      send_word(utbe_pkg::KIND_XMIT, 8'h00);
   endtask

   // EOF is decided at read time, against the code in force then
   task automatic test_eof_at_read_time();
      send_word(utbe_pkg::KIND_RECV, 8'h42);
      send_word(utbe_pkg::KIND_RECV, 8'h55);
      set_eot(8'h55);
      send_word(utbe_pkg::KIND_READ, 8'h00);
      send_word(utbe_pkg::KIND_READ, 8'h00);
   endtask

   // fill both rings past full, then drain them
   task automatic test_ring_overflow();
      run_mix(100, 35, 5, 55);
      run_mix(60, 10, 45, 5);
   endtask

   // balanced traffic with one full drain in the middle
   task automatic test_mixed_traffic(input int count);
      run_mix(count / 2, 25, 25, 25);
      wait_drained();
      repeat ($urandom_range(5, 20)) @(posedge clock);
      run_mix(count - count / 2, 25, 25, 25);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      set_pacing(17, 75);
      test_basic_paths();
      test_eof_at_read_time();

      set_eot(8'h00);
      test_ring_overflow();
      set_eot(utbe_pkg::CH_CR);
      test_mixed_traffic(40);

      set_pacing(75, 17);
      set_eot(8'hFF);
      test_ring_overflow();
      set_eot(utbe_pkg::CH_BS);
      test_mixed_traffic(40);

      set_pacing(0, 0);
      set_eot(utbe_pkg::CH_LF);
      test_mixed_traffic(60);

      wait_drained();
      repeat (10) @(posedge clock);
      if (tty_due.size() != 0)
         note_bad($sformatf("%0d result words never arrived", tty_due.size()));
      if (bad_words == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/utbe_pkg.sv
rtl/utbe_ctrl.sv
rtl/utbe_dpath.sv
rtl/uart_tty_buffer_with_echo_top.sv
test/uart_tty_buffer_with_echo_top_tb.sv
